/* sv/one_wire_master_sequencer_defines.svh */
// ----------------------------------------------------------------------------
// one_wire_master_sequencer_defines
// assertion macros for the 1-wire bus master sequencer
// ----------------------------------------------------------------------------
`ifndef ONE_WIRE_MASTER_SEQUENCER_DEFINES_SVH
`define ONE_WIRE_MASTER_SEQUENCER_DEFINES_SVH

// implication checked on every clock edge outside reset
`define OWMS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("owms implication check failed");

// condition that must hold on the cycle after an event
`define OWMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("owms next-cycle check failed");

`endif

/* sv/owms_pkg.sv */
// ----------------------------------------------------------------------------
// owms_pkg
// types and timing constants of the 1-wire bus master sequencer
// ----------------------------------------------------------------------------
package owms_pkg;

    localparam int TIMER_W = 10;

    localparam logic [TIMER_W-1:0] RESET_LOW_TIME       = 10'd480;
    localparam logic [TIMER_W-1:0] PRESENCE_SAMPLE_TIME = 10'd80;
    localparam logic [TIMER_W-1:0] RESET_RECOVERY_TIME  = 10'd420;
    localparam logic [TIMER_W-1:0] WR1_LOW_TIME         = 10'd6;
    localparam logic [TIMER_W-1:0] WR1_HIGH_TIME        = 10'd64;
    localparam logic [TIMER_W-1:0] WR0_LOW_TIME         = 10'd60;
    localparam logic [TIMER_W-1:0] WR0_HIGH_TIME        = 10'd10;
    localparam logic [TIMER_W-1:0] RD_LOW_TIME          = 10'd6;
    localparam logic [TIMER_W-1:0] RD_SAMPLE_TIME       = 10'd9;
    localparam logic [TIMER_W-1:0] RD_REC_TIME          = 10'd55;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_RESET = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [1:0] ST_PRESENT = 2'd0;
    localparam logic [1:0] ST_NONE    = 2'd1;
    localparam logic [1:0] ST_SHORT   = 2'd2;

    localparam logic [7:0] TPU_RESET = 8'd1;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST_LOW   = 4'd1,
        PH_RST_PRES  = 4'd2,
        PH_RST_REC   = 4'd3,
        PH_WR_LOW    = 4'd4,
        PH_WR_HIGH   = 4'd5,
        PH_RD_LOW    = 4'd6,
        PH_RD_SAMPLE = 4'd7,
        PH_RD_REC    = 4'd8
    } t_phase;

    typedef struct packed {
        logic       line_level;
        logic [7:0] write_data;
        logic [1:0] op;
    } t_item;

    typedef struct packed {
        logic       rejected;
        logic [7:0] read_data;
        logic [1:0] bus_status;
        logic       done_res;
        logic       busy_res;
        logic       drive_low;
    } t_result;

endpackage

/* sv/owms_cfg.sv */
// ----------------------------------------------------------------------------
// owms_cfg
// apb register file holding the microsecond prescaler
// ----------------------------------------------------------------------------
module owms_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  o_ticks_per_us
);
    import owms_pkg::*;

    logic [7:0] r_tpu;
    logic       w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready && (paddr == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpu <= TPU_RESET;
        end else if (w_wr) begin
            r_tpu <= pwdata[7:0];
        end
    end

    assign prdata         = (paddr == 2'd0) ? {24'd0, r_tpu} : 32'd0;
    assign o_ticks_per_us = r_tpu;

endmodule

/* sv/owms_core.sv */
// ----------------------------------------------------------------------------
// owms_core
// sequencer state and single-pass next-state logic for one item
// ----------------------------------------------------------------------------
module owms_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  owms_pkg::t_item  i_item,
    input  logic [7:0]       i_ticks_per_us,
    output owms_pkg::t_result o_result
);
    import owms_pkg::*;

    t_phase             r_phase, n_phase;
    logic [TIMER_W-1:0] r_timer, n_timer;
    logic [7:0]         r_pc, n_pc;
    logic [2:0]         r_bit, n_bit;
    logic [7:0]         r_shift, n_shift;
    logic [1:0]         r_status, n_status;

    logic [7:0] w_lim;
    logic [7:0] w_pc_inc;
    logic [7:0] w_shr;
    logic       w_done;
    logic       w_rej;
    logic [7:0] w_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_timer  <= '0;
            r_pc     <= '0;
            r_bit    <= '0;
            r_shift  <= '0;
            r_status <= ST_NONE;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_timer  <= n_timer;
            r_pc     <= n_pc;
            r_bit    <= n_bit;
            r_shift  <= n_shift;
            r_status <= n_status;
        end
    end

    assign w_lim    = (i_ticks_per_us == 8'd0) ? 8'd1 : i_ticks_per_us;
    assign w_pc_inc = r_pc + 8'd1;
    assign w_shr    = {1'b0, r_shift[7:1]};

    always_comb begin
        n_phase  = r_phase;
        n_timer  = r_timer;
        n_pc     = r_pc;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_status = r_status;
        w_done   = 1'b0;
        w_rej    = 1'b0;
        w_rd     = 8'd0;
        if (i_item.op != OP_TICK) begin
            if (r_phase != PH_IDLE) begin
                w_rej = 1'b1;
            end else begin
                n_pc  = 8'd0;
                n_bit = 3'd0;
                case (i_item.op)
                    OP_RESET: begin
                        n_phase = PH_RST_LOW;
                        n_timer = RESET_LOW_TIME;
                    end
                    OP_WRITE: begin
                        n_shift = i_item.write_data;
                        n_phase = PH_WR_LOW;
                        n_timer = i_item.write_data[0] ? WR1_LOW_TIME : WR0_LOW_TIME;
                    end
                    default: begin
                        n_shift = 8'd0;
                        n_phase = PH_RD_LOW;
                        n_timer = RD_LOW_TIME;
                    end
                endcase
            end
        end else if (r_phase != PH_IDLE) begin
            if (w_pc_inc >= w_lim) begin
                n_pc = 8'd0;
                if (r_timer > 10'd1) begin
                    n_timer = r_timer - 10'd1;
                end else begin
                    case (r_phase)
                        PH_RST_LOW: begin
                            n_phase = PH_RST_PRES;
                            n_timer = PRESENCE_SAMPLE_TIME;
                        end
                        PH_RST_PRES: begin
                            n_status = i_item.line_level ? ST_NONE : ST_PRESENT;
                            n_phase  = PH_RST_REC;
                            n_timer  = RESET_RECOVERY_TIME;
                        end
                        PH_RST_REC: begin
                            if (!i_item.line_level) begin
                                n_status = ST_SHORT;
                            end
                            n_phase = PH_IDLE;
                            n_timer = '0;
                            w_done  = 1'b1;
                        end
                        PH_WR_LOW: begin
                            n_phase = PH_WR_HIGH;
                            n_timer = r_shift[0] ? WR1_HIGH_TIME : WR0_HIGH_TIME;
                        end
                        PH_WR_HIGH: begin
                            n_shift = w_shr;
                            if (r_bit == 3'd7) begin
                                n_bit   = 3'd0;
                                n_phase = PH_IDLE;
                                n_timer = '0;
                                w_done  = 1'b1;
                            end else begin
                                n_bit   = r_bit + 3'd1;
                                n_phase = PH_WR_LOW;
                                n_timer = w_shr[0] ? WR1_LOW_TIME : WR0_LOW_TIME;
                            end
                        end
                        PH_RD_LOW: begin
                            n_phase = PH_RD_SAMPLE;
                            n_timer = RD_SAMPLE_TIME;
                        end
                        PH_RD_SAMPLE: begin
                            n_shift = {i_item.line_level, r_shift[7:1]};
                            n_phase = PH_RD_REC;
                            n_timer = RD_REC_TIME;
                        end
                        PH_RD_REC: begin
                            if (r_bit == 3'd7) begin
                                n_bit   = 3'd0;
                                w_rd    = r_shift;
                                n_phase = PH_IDLE;
                                n_timer = '0;
                                w_done  = 1'b1;
                            end else begin
                                n_bit   = r_bit + 3'd1;
                                n_phase = PH_RD_LOW;
                                n_timer = RD_LOW_TIME;
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                            n_timer = '0;
                        end
                    endcase
                end
            end else begin
                n_pc = w_pc_inc;
            end
        end
    end

    always_comb begin
        o_result.drive_low  = (n_phase == PH_RST_LOW) || (n_phase == PH_WR_LOW) ||
                              (n_phase == PH_RD_LOW);
        o_result.busy_res   = (n_phase != PH_IDLE);
        o_result.done_res   = w_done;
        o_result.bus_status = n_status;
        o_result.read_data  = w_rd;
        o_result.rejected   = w_rej;
    end

endmodule

/* sv/one_wire_master_sequencer.sv */
// ----------------------------------------------------------------------------
// one_wire_master_sequencer
// open-drain 1-wire bus master stepped by tick and command transactions
// ----------------------------------------------------------------------------
// channel   direction  contents
// s_axis    in         tuser op, tdata write_data and line_level
// m_axis    out        one result per input transaction
// apb       in/out     ticks_per_microsecond at byte address 0
//
// one transaction per clock sustained while m_axis accepts results; a stalled m_axis holds
// the flow; the result passes through the input register, then the result register
// the only loop is the sequencer state register updated once per transaction
// synchronous active-low reset clears state, prescaler register reads 1
// a stalled m_axis holds the result; one more input waits in the input register
// ----------------------------------------------------------------------------
module one_wire_master_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // write_data[7:0], line_level[8], zero[15:9]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // drive_low, busy_res, done_res, bus_status[4:3],
                                        // read_data[12:5], rejected[13], zero[15:14]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import owms_pkg::*;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out_result;

    logic       w_out_free;
    logic       w_step;
    logic       w_in_acc;
    logic [7:0] w_tpu;
    t_result    w_result;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_step;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_item.op         <= s_axis_tuser;
            r_in_item.write_data <= s_axis_tdata[7:0];
            r_in_item.line_level <= s_axis_tdata[8];
        end
    end

    owms_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_ticks_per_us (w_tpu)
    );

    owms_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_item         (r_in_item),
        .i_ticks_per_us (w_tpu),
        .o_result       (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_result <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_result};

`include "one_wire_master_sequencer_defines.svh"

    `OWMS_ASSERT_IMPLY(a_drive_needs_busy, m_axis_tvalid && r_out_result.drive_low,
        r_out_result.busy_res)
    `OWMS_ASSERT_IMPLY(a_read_data_on_done, m_axis_tvalid && (r_out_result.read_data != 8'd0),
        r_out_result.done_res)
    `OWMS_ASSERT_IMPLY(a_done_is_final, m_axis_tvalid && r_out_result.done_res,
        !r_out_result.busy_res && !r_out_result.rejected)
    `OWMS_ASSERT_NEXT(a_step_yields_result, w_step, r_out_valid)

endmodule
